// ===== rtl/core/deqr_pkg.sv =====
// ----------------------------------------------------------------------------
// deqr_pkg
// Shared types and codes for the double-ended queue with reverse: request
// and response payloads, action codes and the command that drives the cells.
// ----------------------------------------------------------------------------
package deqr_pkg;

    // Field widths fixed by the interface.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // Action codes carried by a request.
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REM_HEAD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REVERSE  = 3'd4;

    // Command broadcast to every cell of the chain at once.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_PUT_HIGH,
        CELL_DROP_HIGH,
        CELL_CLEAR
    } cell_op_t;

    // Request payload.
    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

endpackage

// ===== rtl/core/deqr_cell.sv =====
// ----------------------------------------------------------------------------
// deqr_cell
// One storage cell of the queue chain. It holds one element and its valid
// bit, and moves data to or from its neighbors as the broadcast command says.
// ----------------------------------------------------------------------------
module deqr_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  deqr_pkg::cell_op_t                 op,
    input  logic signed [deqr_pkg::VALUE_W-1:0] ins_data,
    input  logic signed [deqr_pkg::VALUE_W-1:0] lo_data,
    input  logic                               lo_valid,
    input  logic signed [deqr_pkg::VALUE_W-1:0] hi_data,
    input  logic                               hi_valid,
    output logic signed [deqr_pkg::VALUE_W-1:0] data,
    output logic                               valid,
    output logic signed [deqr_pkg::VALUE_W-1:0] tail_data
);

    logic signed [deqr_pkg::VALUE_W-1:0] data_reg;
    logic signed [deqr_pkg::VALUE_W-1:0] data_next;
    logic                                valid_reg;
    logic                                valid_next;
    logic                                is_last;

    // This cell holds the high end when it is occupied and its upper neighbor is not.
    assign is_last = valid_reg && !hi_valid;

    // Next contents of the cell.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (op)
            deqr_pkg::CELL_SHIFT_UP:
            begin
                data_next  = lo_data;
                valid_next = lo_valid;
            end
            deqr_pkg::CELL_SHIFT_DOWN:
            begin
                data_next  = hi_data;
                valid_next = hi_valid;
            end
            deqr_pkg::CELL_PUT_HIGH:
            begin
                if (!valid_reg && lo_valid)
                begin
                    data_next  = ins_data;
                    valid_next = 1'b1;
                end
            end
            deqr_pkg::CELL_DROP_HIGH:
            begin
                if (is_last)
                begin
                    valid_next = 1'b0;
                end
            end
            deqr_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid bit is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Element payload needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign tail_data = is_last ? data_reg : '0;

endmodule

// ===== rtl/core/double_ended_queue_with_reverse.sv =====
// Each response is captured in the output register when its request is accepted.
// Throughput: one request per cycle while the output register is free; it frees as
// soon as the response is taken, and the cell chain updates every element at once.
// The high-end read is an OR over the one-hot last-cell outputs of the chain.
// Reset empties the queue and clears the reverse flag; no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// Bounded deque of signed 32-bit values kept in a chain of cells, packed from
// cell zero upward. A reverse flag swaps which end of the chain is the head.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  deqr_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deqr_pkg::rsp_t    rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [deqr_pkg::VALUE_W-1:0] cell_data [DEPTH];
    logic                                cell_valid [DEPTH];
    logic signed [deqr_pkg::VALUE_W-1:0] cell_tail [DEPTH];

    deqr_pkg::cell_op_t                  op;
    logic                                accept;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                rev_reg;
    logic                                rev_next;
    logic                                rsp_valid_reg;
    deqr_pkg::rsp_t                      rsp_reg;
    deqr_pkg::rsp_t                      rsp_next;
    logic signed [deqr_pkg::VALUE_W-1:0] tail_value;
    logic                                full;
    logic                                empty;
    logic                                low_end;

    // Handshake: a new request is taken whenever the output register is free.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Chain of cells; cell zero sees the request value as its lower neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [deqr_pkg::VALUE_W-1:0] lo_data;
        logic                                lo_valid;
        logic signed [deqr_pkg::VALUE_W-1:0] hi_data;
        logic                                hi_valid;

        if (i == 0)
        begin : g_low
            assign lo_data  = req.value;
            assign lo_valid = 1'b1;
        end
        else
        begin : g_mid_lo
            assign lo_data  = cell_data[i-1];
            assign lo_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_high
            assign hi_data  = '0;
            assign hi_valid = 1'b0;
        end
        else
        begin : g_mid_hi
            assign hi_data  = cell_data[i+1];
            assign hi_valid = cell_valid[i+1];
        end

        deqr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .ins_data  (req.value),
            .lo_data   (lo_data),
            .lo_valid  (lo_valid),
            .hi_data   (hi_data),
            .hi_valid  (hi_valid),
            .data      (cell_data[i]),
            .valid     (cell_valid[i]),
            .tail_data (cell_tail[i])
        );
    end

    // High-end value: only the last occupied cell drives its data; all others drive zero.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign low_end = ((req.action == deqr_pkg::ACT_INS_HEAD) == !rev_reg);

    // Action decode: cell command, new count, flag and response.
    always_comb
    begin
        op                     = deqr_pkg::CELL_HOLD;
        count_next             = count_reg;
        rev_next               = rev_reg;
        rsp_next.ok            = 1'b0;
        rsp_next.removed_value = '0;
        if (accept)
        begin
            unique case (req.action) inside
                deqr_pkg::ACT_CLEAR:
                begin
                    op          = deqr_pkg::CELL_CLEAR;
                    count_next  = '0;
                    rev_next    = 1'b0;
                    rsp_next.ok = 1'b1;
                end
                deqr_pkg::ACT_INS_HEAD, deqr_pkg::ACT_INS_TAIL:
                begin
                    if (!full)
                    begin
                        op          = low_end ? deqr_pkg::CELL_SHIFT_UP
                                              : deqr_pkg::CELL_PUT_HIGH;
                        count_next  = count_reg + CNT_W'(1);
                        rsp_next.ok = 1'b1;
                    end
                end
                deqr_pkg::ACT_REM_HEAD:
                begin
                    if (!empty)
                    begin
                        if (!rev_reg)
                        begin
                            op                     = deqr_pkg::CELL_SHIFT_DOWN;
                            rsp_next.removed_value = cell_data[0];
                        end
                        else
                        begin
                            op                     = deqr_pkg::CELL_DROP_HIGH;
                            rsp_next.removed_value = tail_value;
                        end
                        count_next  = count_reg - CNT_W'(1);
                        rsp_next.ok = 1'b1;
                    end
                end
                deqr_pkg::ACT_REVERSE:
                begin
                    rev_next    = !rev_reg;
                    rsp_next.ok = 1'b1;
                end
                default:
                begin
                    op = deqr_pkg::CELL_HOLD;
                end
            endcase
        end
        rsp_next.count = deqr_pkg::COUNT_W'(count_next);
    end

    // Control state: count, reverse flag and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== verif/double_ended_queue_with_reverse_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse_tb
// Self-checking bench for the reversible deque. A shadow ring with its own
// head pointer, fill count and reverse flag predicts every response. Traffic
// runs in fill, drain and mixed runs, so the queue often hits full and empty.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse_tb;

    localparam int CLK_PERIOD = 12;
    localparam int RING_DEPTH = 16;
    localparam int ITEM_TOTAL = 1150;

    // Action codes the block must ignore.
    localparam logic [deqr_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [deqr_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [deqr_pkg::ACTION_W-1:0] ACT_SPARE_C = 3'd7;

    typedef enum {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_kind_t;

    // ------------------------------------------------------------------------
    // Shadow deque and the queue of responses still owed by the block.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic signed [deqr_pkg::VALUE_W-1:0] ring [RING_DEPTH];
        int   front;
        int   held;
        bit   flipped;
        deqr_pkg::rsp_t due_responses [$];
        int   errors;
        int   n_insert, n_full_refused, n_remove, n_empty_refused;
        int   n_reverse, n_clear, n_spare;

        function new();
            front   = 0;
            held    = 0;
            flipped = 1'b0;
            errors  = 0;
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        function int pending();
            return due_responses.size();
        endfunction

        // Apply one action to the shadow deque and return its response.
        function deqr_pkg::rsp_t apply_action(deqr_pkg::req_t r);
            deqr_pkg::rsp_t res;
            bit             low_end;
            res = '0;
            case (r.action) inside
                deqr_pkg::ACT_CLEAR:
                begin
                    front   = 0;
                    held    = 0;
                    flipped = 1'b0;
                    res.ok  = 1'b1;
                    n_clear++;
                end
                deqr_pkg::ACT_INS_HEAD, deqr_pkg::ACT_INS_TAIL:
                begin
                    n_insert++;
                    if (held < RING_DEPTH)
                    begin
                        // Head inserts go below the front unless reversed.
                        low_end = ((r.action == deqr_pkg::ACT_INS_HEAD) == !flipped);
                        if (low_end)
                        begin
                            front = (front + RING_DEPTH - 1) % RING_DEPTH;
                            ring[front] = r.value;
                        end
                        else
                        begin
                            ring[(front + held) % RING_DEPTH] = r.value;
                        end
                        held++;
                        res.ok = 1'b1;
                    end
                    else
                    begin
                        n_full_refused++;
                    end
                end
                deqr_pkg::ACT_REM_HEAD:
                begin
                    n_remove++;
                    if (held != 0)
                    begin
                        if (!flipped)
                        begin
                            res.removed_value = ring[front];
                            front = (front + 1) % RING_DEPTH;
                        end
                        else
                        begin
                            res.removed_value = ring[(front + held - 1) % RING_DEPTH];
                        end
                        held--;
                        res.ok = 1'b1;
                    end
                    else
                    begin
                        n_empty_refused++;
                    end
                end
                deqr_pkg::ACT_REVERSE:
                begin
                    flipped = !flipped;
                    res.ok  = 1'b1;
                    n_reverse++;
                end
                default:
                begin
                    n_spare++;
                end
            endcase
            res.count = held[deqr_pkg::COUNT_W-1:0];
            return res;
        endfunction

        function void note_request(deqr_pkg::req_t r);
            due_responses.push_back(apply_action(r));
        endfunction

        task check_response(deqr_pkg::rsp_t got);
            deqr_pkg::rsp_t want;
            if (due_responses.size() == 0)
            begin
                report($sformatf("unexpected response (ok=%0b value=%0d count=%0d)",
                                 got.ok, got.removed_value, got.count));
            end
            else
            begin
                want = due_responses.pop_front();
                if (got.ok !== want.ok)
                    report($sformatf("ok %b, expected %b", got.ok, want.ok));
                if (got.removed_value !== want.removed_value)
                    report($sformatf("removed_value %0d, expected %0d",
                                     got.removed_value, want.removed_value));
                if (got.count !== want.count)
                    report($sformatf("count %0d, expected %0d", got.count, want.count));
            end
        endtask

        task report_leftovers();
            if (due_responses.size() != 0)
                report($sformatf("%0d responses never arrived", due_responses.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and the block itself.
    // ------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    deqr_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    deqr_pkg::rsp_t rsp;

    bit   steady    = 1'b0;
    int   sent      = 0;
    int   stall_left = 0;

    deque_scoreboard sb = new();

    always #(CLK_PERIOD / 2) clk = ~clk;

    double_ended_queue_with_reverse #(
        .DEPTH (RING_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Idle length: mostly none, often short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Values lean on the extremes now and then.
    function automatic logic signed [deqr_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    // Action mix depends on whether the run is meant to fill or drain.
    function automatic logic [deqr_pkg::ACTION_W-1:0] pick_action(run_kind_t kind);
        int r;
        int insert_pct;
        r = $urandom_range(0, 99);
        if (r < 1)
            return deqr_pkg::ACT_CLEAR;
        if (r < 3)
            return deqr_pkg::ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        if (r < 10)
            return deqr_pkg::ACT_REVERSE;
        case (kind)
            FILL_RUN:  insert_pct = 88;
            DRAIN_RUN: insert_pct = 12;
            default:   insert_pct = 50;
        endcase
        if ($urandom_range(0, 99) < insert_pct)
            return $urandom_range(0, 1) ? deqr_pkg::ACT_INS_HEAD : deqr_pkg::ACT_INS_TAIL;
        return deqr_pkg::ACT_REM_HEAD;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [deqr_pkg::ACTION_W-1:0] action,
                                input logic signed [deqr_pkg::VALUE_W-1:0] value);
        deqr_pkg::req_t item;
        int             gap;
        item.action = action;
        item.value  = value;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    // Stop sending until every outstanding response is back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Response side: ready high except for random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 9) == 0)
                stall_left = idle_gap();
        end
    end

    // Monitor: predict on every accepted request, check every taken response.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("timeout with %0d responses outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        run_kind_t kind;
        int        run_len;
        int        spin;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty removes, reverse on empty, extreme values at both
        // ends, removes in both directions, ignored codes and clear.
        send_request(deqr_pkg::ACT_REM_HEAD, pick_value());
        send_request(deqr_pkg::ACT_REVERSE, pick_value());
        send_request(deqr_pkg::ACT_REM_HEAD, pick_value());
        send_request(deqr_pkg::ACT_INS_HEAD, 32'sh8000_0000);
        send_request(deqr_pkg::ACT_INS_TAIL, 32'sh7FFF_FFFF);
        send_request(deqr_pkg::ACT_REVERSE, pick_value());
        send_request(deqr_pkg::ACT_INS_HEAD, '0);
        send_request(deqr_pkg::ACT_INS_TAIL, -32'sd1);
        send_request(deqr_pkg::ACT_REM_HEAD, pick_value());
        send_request(deqr_pkg::ACT_REVERSE, pick_value());
        send_request(deqr_pkg::ACT_REM_HEAD, pick_value());
        send_request(ACT_SPARE_A, pick_value());
        send_request(ACT_SPARE_B, pick_value());
        send_request(ACT_SPARE_C, pick_value());
        send_request(deqr_pkg::ACT_CLEAR, pick_value());
        send_request(deqr_pkg::ACT_REM_HEAD, pick_value());
        wait_for_drain();

        // Random runs; the first one is a long fill run that is likely to overflow the queue.
        kind    = FILL_RUN;
        run_len = 50;
        while (sent < ITEM_TOTAL)
        begin
            steady = ($urandom_range(0, 4) == 0);
            repeat (run_len)
                send_request(pick_action(kind), pick_value());
            if (kind == FILL_RUN || $urandom_range(0, 3) == 0)
                wait_for_drain();
            case ($urandom_range(0, 2))
                0:       kind = FILL_RUN;
                1:       kind = DRAIN_RUN;
                default: kind = MIXED_RUN;
            endcase
            run_len = $urandom_range(20, 60);
        end
        steady = 1'b0;

        // Let the last responses come back before the final report.
        req_valid <= 1'b0;
        spin = 0;
        do
        begin
            @(posedge clk);
            spin++;
        end
        while (sb.pending() != 0 && spin < 100000);
        repeat (4) @(posedge clk);
        sb.report_leftovers();

        $display("Sent %0d requests: %0d inserts (%0d refused when full),",
                 sent, sb.n_insert, sb.n_full_refused);
        $display("%0d removes (%0d on empty), %0d reverses, %0d clears, %0d ignored codes.",
                 sb.n_remove, sb.n_empty_refused, sb.n_reverse, sb.n_clear, sb.n_spare);
        $display("%0d mismatches.", sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
